[rtl/core/bnms_pkg.sv]
// bnms_pkg: shared types and constants of the box non-max suppression block
// controller states, command and status structs, item payload structs
// no dependencies
package bnms_pkg;

	localparam int RESULT_LIMIT = 64;
	localparam logic [10:0] THR_RESET = 11'd461;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SORT_INIT,
		ST_SORT_RD,
		ST_SORT_LAT,
		ST_SORT_RUN,
		ST_SORT_WR,
		ST_NMS_INIT,
		ST_NMS_RD,
		ST_NMS_RDA,
		ST_NMS_LAT,
		ST_NMS_RUN,
		ST_NMS_NEXT,
		ST_OUT_START,
		ST_OUT_RD,
		ST_OUT_RDB,
		ST_OUT_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_en;
		logic init_i;
		logic sort_rd;
		logic sort_lat;
		logic sort_run;
		logic rank_wr;
		logic next_i;
		logic nms_lat_a;
		logic nms_run;
		logic out_load;
		logic clear_set;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic n_zero;
		logic i_last;
		logic run_done;
		logic supp_i;
		logic out_free;
		logic out_last;
	} stat_t;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] score;
		logic [6:0]  label;
		logic        final_box;
	} box_t;

	typedef struct packed {
		logic [15:0] kept_x;
		logic [15:0] kept_y;
		logic [15:0] kept_width;
		logic [15:0] kept_height;
		logic [15:0] kept_score;
		logic [6:0]  kept_label;
		logic        dropped_some;
		logic        final_kept;
	} kept_t;

endpackage

[rtl/core/bnms_box_if.sv]
// bnms_box_if: input channel carrying one candidate box per item
// valid/ready handshake, no dependencies
interface bnms_box_if;
	logic        valid;
	logic        ready;
	logic [15:0] center_x;
	logic [15:0] center_y;
	logic [15:0] box_width;
	logic [15:0] box_height;
	logic [15:0] score;
	logic [6:0]  label;
	logic        final_box;

	modport source (output valid, center_x, center_y, box_width, box_height, score, label,
		final_box, input ready);
	modport sink (input valid, center_x, center_y, box_width, box_height, score, label,
		final_box, output ready);
endinterface

[rtl/core/bnms_kept_if.sv]
// bnms_kept_if: output channel carrying one surviving box per item
// valid/ready handshake, no dependencies
interface bnms_kept_if;
	logic        valid;
	logic        ready;
	logic [15:0] kept_x;
	logic [15:0] kept_y;
	logic [15:0] kept_width;
	logic [15:0] kept_height;
	logic [15:0] kept_score;
	logic [6:0]  kept_label;
	logic        dropped_some;
	logic        final_kept;

	modport source (output valid, kept_x, kept_y, kept_width, kept_height, kept_score,
		kept_label, dropped_some, final_kept, input ready);
	modport sink (input valid, kept_x, kept_y, kept_width, kept_height, kept_score,
		kept_label, dropped_some, final_kept, output ready);
endinterface

[rtl/core/box_non_max_suppression.sv]
// box_non_max_suppression: greedy per-class non-max suppression, top level
// instantiates bnms_ctrl and bnms_dp; uses bnms_pkg, bnms_box_if, bnms_kept_if
//
// box_in takes one candidate box per item, one item a cycle while loading;
// the item with final_box high closes the set. Up to MAX_BOXES boxes are
// stored, later ones are dropped and dropped_some is set on every result.
// After the close the block stops taking items and works the set of n boxes:
// rank sort with one score compare a cycle; then the suppression sweep, one
// pair IoU test a cycle through a pipeline; then one result item per
// survivor, up to RESULT_LIMIT, in descending score order with final_kept
// on the last. The stores have one read port each. kept_out holds an item
// until it is taken; a stall just holds the sequencer. After the last item
// is loaded into the output register, loading of the next set starts while
// it waits. cfg_we writes the IoU threshold; write it only while idle.
// Reset empties the set, sets the threshold to 461 and leaves the stores
// unwritten.
module box_non_max_suppression #(
	parameter int MAX_BOXES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	bnms_box_if.sink    box_in,
	bnms_kept_if.source kept_out
);
	import bnms_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	box_t  in_box;
	kept_t out_item;
	logic  in_ready, out_valid;

	assign in_box = '{center_x: box_in.center_x, center_y: box_in.center_y,
		box_width: box_in.box_width, box_height: box_in.box_height,
		score: box_in.score, label: box_in.label, final_box: box_in.final_box};
	assign box_in.ready = in_ready;

	assign kept_out.valid        = out_valid;
	assign kept_out.kept_x       = out_item.kept_x;
	assign kept_out.kept_y       = out_item.kept_y;
	assign kept_out.kept_width   = out_item.kept_width;
	assign kept_out.kept_height  = out_item.kept_height;
	assign kept_out.kept_score   = out_item.kept_score;
	assign kept_out.kept_label   = out_item.kept_label;
	assign kept_out.dropped_some = out_item.dropped_some;
	assign kept_out.final_kept   = out_item.final_kept;

	bnms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	bnms_dp #(
		.MAX_BOXES (MAX_BOXES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (box_in.valid),
		.in_box    (in_box),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (kept_out.ready),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

[rtl/core/bnms_ctrl.sv]
// bnms_ctrl: sequencer for load, rank sort, suppression sweep and output
// uses bnms_pkg state, command and status types
module bnms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  bnms_pkg::stat_t stat,
	output bnms_pkg::cmd_t  cmd
);
	import bnms_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:      if (stat.close) state_d = ST_SORT_INIT;
			ST_SORT_INIT: state_d = stat.n_zero ? ST_DONE : ST_SORT_RD;
			ST_SORT_RD:   state_d = ST_SORT_LAT;
			ST_SORT_LAT:  state_d = ST_SORT_RUN;
			ST_SORT_RUN:  if (stat.run_done) state_d = ST_SORT_WR;
			ST_SORT_WR:   state_d = stat.i_last ? ST_NMS_INIT : ST_SORT_RD;
			ST_NMS_INIT:  state_d = ST_NMS_RD;
			ST_NMS_RD:    state_d = ST_NMS_RDA;
			ST_NMS_RDA:   state_d = stat.supp_i ? ST_NMS_NEXT : ST_NMS_LAT;
			ST_NMS_LAT:   state_d = ST_NMS_RUN;
			ST_NMS_RUN:   if (stat.run_done) state_d = ST_NMS_NEXT;
			ST_NMS_NEXT:  state_d = stat.i_last ? ST_OUT_START : ST_NMS_RD;
			ST_OUT_START: state_d = ST_OUT_RD;
			ST_OUT_RD:    state_d = ST_OUT_RDB;
			ST_OUT_RDB:   state_d = stat.supp_i ? ST_OUT_RD : ST_OUT_LOAD;
			ST_OUT_LOAD: begin
				if (stat.out_free) state_d = stat.out_last ? ST_DONE : ST_OUT_RD;
			end
			ST_DONE:      state_d = ST_LOAD;
			default:      state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:      cmd.load_en = 1'b1;
			ST_SORT_INIT: cmd.init_i = 1'b1;
			ST_SORT_RD:   cmd.sort_rd = 1'b1;
			ST_SORT_LAT:  cmd.sort_lat = 1'b1;
			ST_SORT_RUN:  cmd.sort_run = 1'b1;
			ST_SORT_WR: begin
				cmd.rank_wr = 1'b1;
				cmd.next_i = 1'b1;
			end
			ST_NMS_INIT:  cmd.init_i = 1'b1;
			ST_NMS_RD:    cmd = '0;
			ST_NMS_RDA:   cmd = '0;
			ST_NMS_LAT:   cmd.nms_lat_a = 1'b1;
			ST_NMS_RUN:   cmd.nms_run = 1'b1;
			ST_NMS_NEXT:  cmd.next_i = 1'b1;
			ST_OUT_START: cmd.init_i = 1'b1;
			ST_OUT_RD:    cmd = '0;
			ST_OUT_RDB:   cmd.next_i = stat.supp_i;
			ST_OUT_LOAD:  cmd.out_load = 1'b1;
			ST_DONE:      cmd.clear_set = 1'b1;
			default:      cmd = '0;
		endcase
	end

endmodule

[rtl/core/bnms_dp.sv]
// bnms_dp: box stores, rank sort counter, pipelined IoU test and output register
// driven by bnms_ctrl commands; uses bnms_pkg types and constants
module bnms_dp #(
	parameter int MAX_BOXES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [10:0]     cfg_wdata,
	input  logic            in_valid,
	input  bnms_pkg::box_t  in_box,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bnms_pkg::kept_t out_item,
	input  bnms_pkg::cmd_t  cmd,
	output bnms_pkg::stat_t stat
);
	import bnms_pkg::*;

	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int LIMIT = (MAX_BOXES < RESULT_LIMIT) ? MAX_BOXES : RESULT_LIMIT;

	logic [63:0]   geo_mem  [MAX_BOXES];
	logic [22:0]   sl_mem   [MAX_BOXES];
	logic [IW-1:0] rank_mem [MAX_BOXES];
	logic          supp_mem [MAX_BOXES];

	logic [63:0]   geo_rdata;
	logic [22:0]   sl_rdata;
	logic [IW-1:0] rank_rdata;
	logic          supp_rdata;
	logic [IW-1:0] box_raddr, pos_raddr;

	logic [10:0]   thr_q;
	logic [CW-1:0] cnt_q, i_q, j_q, acc_q, supp_cnt_q, emit_q;
	logic          ovf_q;
	logic [15:0]   si_q;
	logic          in_acc, issue, sv1_q, hit;
	logic [CW-1:0] surv, total;

	logic signed [18:0] a_lo_x_q, a_hi_x_q, a_lo_y_q, a_hi_y_q;
	logic [33:0]        a_area_q;
	logic [6:0]         a_lbl_q;

	logic signed [18:0] b_lo_x, b_hi_x, b_lo_y, b_hi_y, ix1, ix2, iy1, iy2, dx, dy;
	logic [33:0]        b_area;

	logic [6:1]    nv;
	logic [CW-1:0] j_s1, j_s2, j_s3, j_s4, j_s5, j_s6;
	logic [17:0]   iw_s3, ih_s3;
	logic [33:0]   ab_s3, ab_s4;
	logic          leq_s3;
	logic [35:0]   inter_s4, inter_s5, inter_s6, uni_s5;
	logic [46:0]   prod_s6;

	assign in_ready = cmd.load_en;
	assign in_acc = in_valid && cmd.load_en;
	assign issue = j_q < cnt_q;

	always_comb begin
		if (cmd.sort_rd) begin
			box_raddr = i_q[IW-1:0];
		end else if (cmd.sort_run) begin
			box_raddr = j_q[IW-1:0];
		end else begin
			box_raddr = rank_rdata;
		end
		pos_raddr = cmd.nms_run ? j_q[IW-1:0] : i_q[IW-1:0];
	end

	// box stores
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CW'(MAX_BOXES))) begin
			geo_mem[cnt_q[IW-1:0]] <= {in_box.center_x, in_box.center_y,
				in_box.box_width, in_box.box_height};
			sl_mem[cnt_q[IW-1:0]] <= {in_box.score, in_box.label};
		end
		if (cmd.rank_wr) begin
			rank_mem[acc_q[IW-1:0]] <= i_q[IW-1:0];
		end
		if (in_acc && (cnt_q < CW'(MAX_BOXES))) begin
			supp_mem[cnt_q[IW-1:0]] <= 1'b0;
		end else if (hit) begin
			supp_mem[j_s6[IW-1:0]] <= 1'b1;
		end
		geo_rdata  <= geo_mem[box_raddr];
		sl_rdata   <= sl_mem[box_raddr];
		rank_rdata <= rank_mem[pos_raddr];
		supp_rdata <= supp_mem[pos_raddr];
	end

	// set control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			supp_cnt_q <= '0;
			emit_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			acc_q      <= '0;
			sv1_q      <= 1'b0;
			nv         <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (in_acc) begin
				if (cnt_q < CW'(MAX_BOXES)) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clear_set) begin
				cnt_q      <= '0;
				ovf_q      <= 1'b0;
				supp_cnt_q <= '0;
				emit_q     <= '0;
			end
			if (hit) supp_cnt_q <= supp_cnt_q + 1'b1;

			if (cmd.init_i) begin
				i_q    <= '0;
				emit_q <= '0;
			end else if (cmd.next_i || (cmd.out_load && stat.out_free)) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.out_load && stat.out_free) emit_q <= emit_q + 1'b1;

			if (cmd.sort_lat) begin
				j_q   <= '0;
				acc_q <= '0;
			end else if (cmd.nms_lat_a) begin
				j_q <= i_q + 1'b1;
			end else if ((cmd.sort_run || cmd.nms_run) && issue) begin
				j_q <= j_q + 1'b1;
			end

			sv1_q <= cmd.sort_run && issue;
			if (sv1_q && ((sl_rdata[22:7] > si_q) ||
					((sl_rdata[22:7] == si_q) && (j_s1 < i_q)))) begin
				acc_q <= acc_q + 1'b1;
			end

			nv[1] <= cmd.nms_run && issue;
			nv[2] <= nv[1] && !supp_rdata;
			nv[3] <= nv[2];
			nv[4] <= nv[3] && leq_s3;
			nv[5] <= nv[4];
			nv[6] <= nv[5];

			if (cmd.out_load && stat.out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// geometry of box b
	always_comb begin
		b_lo_x = $signed({2'b00, geo_rdata[63:48], 1'b0}) - $signed({3'b000, geo_rdata[31:16]});
		b_hi_x = $signed({2'b00, geo_rdata[63:48], 1'b0}) + $signed({3'b000, geo_rdata[31:16]});
		b_lo_y = $signed({2'b00, geo_rdata[47:32], 1'b0}) - $signed({3'b000, geo_rdata[15:0]});
		b_hi_y = $signed({2'b00, geo_rdata[47:32], 1'b0}) + $signed({3'b000, geo_rdata[15:0]});
		ix1 = (a_lo_x_q > b_lo_x) ? a_lo_x_q : b_lo_x;
		ix2 = (a_hi_x_q < b_hi_x) ? a_hi_x_q : b_hi_x;
		iy1 = (a_lo_y_q > b_lo_y) ? a_lo_y_q : b_lo_y;
		iy2 = (a_hi_y_q < b_hi_y) ? a_hi_y_q : b_hi_y;
		dx = ix2 - ix1;
		dy = iy2 - iy1;
		b_area = {geo_rdata[31:16], 1'b0} * {geo_rdata[15:0], 1'b0};
	end

	assign hit = nv[6] && ({1'b0, inter_s6, 10'b0} > prod_s6);

	// payload pipeline
	always_ff @(posedge clk) begin
		if (cmd.sort_lat) si_q <= sl_rdata[22:7];
		if (cmd.nms_lat_a) begin
			a_lo_x_q <= b_lo_x;
			a_hi_x_q <= b_hi_x;
			a_lo_y_q <= b_lo_y;
			a_hi_y_q <= b_hi_y;
			a_area_q <= b_area;
			a_lbl_q  <= sl_rdata[6:0];
		end
		j_s1     <= j_q;
		j_s2     <= j_s1;
		j_s3     <= j_s2;
		iw_s3    <= dx[18] ? 18'd0 : dx[17:0];
		ih_s3    <= dy[18] ? 18'd0 : dy[17:0];
		ab_s3    <= b_area;
		leq_s3   <= sl_rdata[6:0] == a_lbl_q;
		j_s4     <= j_s3;
		inter_s4 <= iw_s3 * ih_s3;
		ab_s4    <= ab_s3;
		j_s5     <= j_s4;
		uni_s5   <= 36'(a_area_q) + 36'(ab_s4) - inter_s4;
		inter_s5 <= inter_s4;
		j_s6     <= j_s5;
		prod_s6  <= thr_q * uni_s5;
		inter_s6 <= inter_s5;
		if (cmd.out_load && stat.out_free) begin
			out_item.kept_x       <= geo_rdata[63:48];
			out_item.kept_y       <= geo_rdata[47:32];
			out_item.kept_width   <= geo_rdata[31:16];
			out_item.kept_height  <= geo_rdata[15:0];
			out_item.kept_score   <= sl_rdata[22:7];
			out_item.kept_label   <= sl_rdata[6:0];
			out_item.dropped_some <= ovf_q;
			out_item.final_kept   <= stat.out_last;
		end
	end

	assign surv  = cnt_q - supp_cnt_q;
	assign total = (surv > CW'(LIMIT)) ? CW'(LIMIT) : surv;

	always_comb begin
		stat.close    = in_acc && in_box.final_box;
		stat.n_zero   = cnt_q == '0;
		stat.i_last   = (i_q + 1'b1) == cnt_q;
		stat.run_done = !issue && !sv1_q && !(|nv);
		stat.supp_i   = supp_rdata;
		stat.out_free = !out_valid || out_ready;
		stat.out_last = (emit_q + 1'b1) == total;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BOXES))
		else $error("box count beyond capacity");
	a_supp_later: assert property (@(posedge clk) disable iff (!arst_n)
		nv[6] |-> (j_s6 > i_q))
		else $error("suppression aimed at a box not after the kept one");
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_wr |-> (acc_q < cnt_q))
		else $error("rank beyond set size");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= total)
		else $error("more items emitted than survivors");

endmodule
